[hdl/tti_pkg.sv]
// shared types, constants and microcode rom for the terminal escape interpreter
package tti_pkg;

  localparam int ROWS   = 10;
  localparam int COLS   = 10;
  localparam int CELLS  = ROWS * COLS;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_W  = $clog2(COLS);
  localparam int ADDR_W = $clog2(CELLS);
  localparam int UPC_W  = 5;

  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [UPC_W-1:0]  upc_t;

  localparam logic [7:0] CH_CARET   = 8'h5E;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_CLEAR   = 8'h63;
  localparam logic [7:0] CH_ERASE   = 8'h65;
  localparam logic [7:0] CH_INS_ON  = 8'h69;
  localparam logic [7:0] CH_INS_OFF = 8'h6F;
  localparam logic [7:0] CH_HOME    = 8'h68;
  localparam logic [7:0] CH_BOL     = 8'h62;
  localparam logic [7:0] CH_DOWN    = 8'h64;
  localparam logic [7:0] CH_UP      = 8'h75;
  localparam logic [7:0] CH_LEFT    = 8'h6C;
  localparam logic [7:0] CH_RIGHT   = 8'h72;
  localparam logic [7:0] CH_DIG_LO  = 8'h30;
  localparam logic [7:0] CH_DIG_HI  = 8'h39;

  typedef struct packed {
    logic       func;
    logic [7:0] code_byte;
    logic [3:0] read_row;
    logic [3:0] read_col;
  } in_item_t;

  typedef struct packed {
    logic [7:0] cell_char;
    logic [3:0] cursor_row;
    logic [3:0] cursor_col;
    logic       insert_on;
    logic       control_pending;
  } out_item_t;

  // datapath actions, one per control word
  typedef enum logic [3:0] {
    A_NOP, A_ACCEPT, A_RD_REQ, A_RD_DONE, A_CTL_SET, A_INS_INIT, A_SHIFT_RD,
    A_SHIFT_WR, A_PUT, A_CLEAR, A_ERASE_INIT, A_ERASE_WR, A_MISC, A_EMIT
  } act_t;

  // jump conditions
  typedef enum logic [3:0] {
    C_ALWAYS, C_FIRE, C_FUNC_RD, C_NEWLINE, C_PLAIN, C_CARET, C_CLEAR_CODE,
    C_ERASE_CODE, C_NO_INS, C_SHIFT_DONE, C_ERASE_LAST, C_OUT_FREE
  } cond_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    upc_t  target;
    logic  hold;   // stay on this step when the condition is false
  } ctrl_word_t;

  typedef struct packed {
    logic fire;
    logic func_rd;
    logic newline;
    logic in_ctl;
    logic caret;
    logic clear_code;
    logic erase_code;
    logic ins;
    logic shift_done;
    logic erase_last;
    logic out_free;
  } tti_stat_t;

  localparam upc_t U_IDLE     = 5'd0;
  localparam upc_t U_DISP     = 5'd1;
  localparam upc_t U_CHK_NL   = 5'd2;
  localparam upc_t U_CHK_CTL  = 5'd3;
  localparam upc_t U_CHK_CAR  = 5'd4;
  localparam upc_t U_CHK_CLR  = 5'd5;
  localparam upc_t U_CHK_ERA  = 5'd6;
  localparam upc_t U_MISC     = 5'd7;
  localparam upc_t U_PLAIN    = 5'd8;
  localparam upc_t U_INS      = 5'd9;
  localparam upc_t U_SH_RD    = 5'd10;
  localparam upc_t U_SH_WR    = 5'd11;
  localparam upc_t U_PUT      = 5'd12;
  localparam upc_t U_CLR      = 5'd13;
  localparam upc_t U_ERA      = 5'd14;
  localparam upc_t U_ERA_WR   = 5'd15;
  localparam upc_t U_SET_CTL  = 5'd16;
  localparam upc_t U_RD_REQ   = 5'd17;
  localparam upc_t U_RD_DONE  = 5'd18;
  localparam upc_t U_EMIT     = 5'd19;

  function automatic ctrl_word_t mk(act_t a, cond_t c, upc_t t, logic h);
    ctrl_word_t w;
    w.act    = a;
    w.cond   = c;
    w.target = t;
    w.hold   = h;
    return w;
  endfunction

  function automatic ctrl_word_t microcode(upc_t a);
    ctrl_word_t w;
    unique case (a)
      U_IDLE:    w = mk(A_ACCEPT,     C_FIRE,       U_DISP,    1'b1);
      U_DISP:    w = mk(A_NOP,        C_FUNC_RD,    U_RD_REQ,  1'b0);
      U_CHK_NL:  w = mk(A_NOP,        C_NEWLINE,    U_EMIT,    1'b0);
      U_CHK_CTL: w = mk(A_NOP,        C_PLAIN,      U_PLAIN,   1'b0);
      U_CHK_CAR: w = mk(A_NOP,        C_CARET,      U_INS,     1'b0);
      U_CHK_CLR: w = mk(A_NOP,        C_CLEAR_CODE, U_CLR,     1'b0);
      U_CHK_ERA: w = mk(A_NOP,        C_ERASE_CODE, U_ERA,     1'b0);
      U_MISC:    w = mk(A_MISC,       C_ALWAYS,     U_EMIT,    1'b0);
      U_PLAIN:   w = mk(A_NOP,        C_CARET,      U_SET_CTL, 1'b0);
      U_INS:     w = mk(A_INS_INIT,   C_NO_INS,     U_PUT,     1'b0);
      U_SH_RD:   w = mk(A_SHIFT_RD,   C_SHIFT_DONE, U_PUT,     1'b0);
      U_SH_WR:   w = mk(A_SHIFT_WR,   C_ALWAYS,     U_SH_RD,   1'b0);
      U_PUT:     w = mk(A_PUT,        C_ALWAYS,     U_EMIT,    1'b0);
      U_CLR:     w = mk(A_CLEAR,      C_ALWAYS,     U_EMIT,    1'b0);
      U_ERA:     w = mk(A_ERASE_INIT, C_ALWAYS,     U_ERA_WR,  1'b0);
      U_ERA_WR:  w = mk(A_ERASE_WR,   C_ERASE_LAST, U_EMIT,    1'b1);
      U_SET_CTL: w = mk(A_CTL_SET,    C_ALWAYS,     U_EMIT,    1'b0);
      U_RD_REQ:  w = mk(A_RD_REQ,     C_ALWAYS,     U_RD_DONE, 1'b0);
      U_RD_DONE: w = mk(A_RD_DONE,    C_ALWAYS,     U_EMIT,    1'b0);
      U_EMIT:    w = mk(A_EMIT,       C_OUT_FREE,   U_IDLE,    1'b1);
      default:   w = mk(A_NOP,        C_ALWAYS,     U_IDLE,    1'b0);
    endcase
    return w;
  endfunction

  function automatic addr_t cell_addr(row_t r, col_t c);
    return ADDR_W'(r) * ADDR_W'(COLS) + ADDR_W'(c);
  endfunction

endpackage

[hdl/text_terminal_escape_interpreter_unit.sv]
// top level: terminal escape interpreter datapath around a microcoded sequencer
//
//   channel  | ports                          | payload
//   ---------+--------------------------------+-----------------------------
//   input    | in_valid, in_stall, in_data    | in_item_t  (feed byte / read)
//   result   | out_valid, out_stall, out_data | out_item_t (cell and cursor)
//
// newline and read items are the short cases; insert-mode printing is the
// long case, shifting cells one by one through the single read and single
// write port of the screen memory, and erase writes the cleared cells one
// after another.
// reset is synchronous: all cells read as space at once through the valid bits.
// a result waits in the output register while out_stall is high; the next
// transaction is taken meanwhile and only its own result step waits.
module text_terminal_escape_interpreter_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tti_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tti_pkg::out_item_t out_data
);
  import tti_pkg::*;

  localparam col_t COL_LAST = col_t'(COLS - 1);
  localparam row_t ROW_LAST = row_t'(ROWS - 1);

  ctrl_word_t cw;
  tti_stat_t  stat;

  // latched transaction
  logic       func_r,  func_nxt;
  logic [7:0] code_r,  code_nxt;
  logic [3:0] rrow_r,  rrow_nxt;
  logic [3:0] rcol_r,  rcol_nxt;

  // architectural state
  row_t row_r, row_nxt;
  col_t col_r, col_nxt;
  logic ins_r, ins_nxt;
  logic ctl_r, ctl_nxt;
  logic awc_r, awc_nxt;

  // loop column and result holding
  col_t       k_r,    k_nxt;
  logic [7:0] cell_r, cell_nxt;
  out_item_t  out_r,  out_nxt;
  logic       out_valid_r, out_valid_nxt;

  // screen port controls
  logic       mem_clr;
  logic       mem_we;
  addr_t      mem_waddr;
  logic [7:0] mem_wdata;
  logic       mem_re;
  addr_t      mem_raddr;
  logic [7:0] mem_rdata;

  logic       fire;
  logic       rd_inrange;
  logic [3:0] dig;

  tti_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cw    (cw)
  );

  tti_screen u_screen (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (mem_clr),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // input taken only on the idle step of the program
  assign in_stall = (cw.act != A_ACCEPT);
  assign fire     = in_valid && !in_stall;

  assign rd_inrange = (rrow_r < 4'(ROWS)) && (rcol_r < 4'(COLS));
  assign dig        = code_r[3:0];

  always_comb begin
    stat.fire       = fire;
    stat.func_rd    = func_r;
    stat.newline    = (code_r == CH_NEWLINE);
    stat.in_ctl     = ctl_r;
    stat.caret      = (code_r == CH_CARET);
    stat.clear_code = (code_r == CH_CLEAR);
    stat.erase_code = (code_r == CH_ERASE);
    stat.ins        = ins_r;
    stat.shift_done = !(k_r > col_r);
    stat.erase_last = (k_r == COL_LAST);
    stat.out_free   = !out_valid_r || !out_stall;
  end

  always_comb begin
    func_nxt      = func_r;
    code_nxt      = code_r;
    rrow_nxt      = rrow_r;
    rcol_nxt      = rcol_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    ins_nxt       = ins_r;
    ctl_nxt       = ctl_r;
    awc_nxt       = awc_r;
    k_nxt         = k_r;
    cell_nxt      = cell_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    mem_clr       = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = cell_addr(row_r, col_r);
    mem_wdata     = code_r;
    mem_re        = 1'b0;
    mem_raddr     = cell_addr(row_r, k_r - col_t'(1));

    unique case (cw.act)
      A_NOP: begin
      end
      A_ACCEPT: begin
        if (fire) begin
          func_nxt = in_data.func;
          code_nxt = in_data.code_byte;
          rrow_nxt = in_data.read_row;
          rcol_nxt = in_data.read_col;
          cell_nxt = 8'h00;
        end
      end
      A_RD_REQ: begin
        mem_re    = rd_inrange;
        mem_raddr = cell_addr(row_t'(rrow_r), col_t'(rcol_r));
      end
      A_RD_DONE: begin
        cell_nxt = rd_inrange ? mem_rdata : 8'h00;
      end
      A_CTL_SET: begin
        ctl_nxt = 1'b1;
      end
      A_INS_INIT: begin
        k_nxt = COL_LAST;
      end
      A_SHIFT_RD: begin
        // fetch the left neighbor of the cell about to be overwritten
        mem_re = !stat.shift_done;
      end
      A_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = cell_addr(row_r, k_r);
        mem_wdata = mem_rdata;
        k_nxt     = k_r - col_t'(1);
      end
      A_PUT: begin
        mem_we  = 1'b1;
        ctl_nxt = 1'b0;
        if (col_r < COL_LAST) begin
          col_nxt = col_r + col_t'(1);
        end
      end
      A_CLEAR: begin
        mem_clr = 1'b1;
        ctl_nxt = 1'b0;
      end
      A_ERASE_INIT: begin
        k_nxt   = col_r;
        ctl_nxt = 1'b0;
      end
      A_ERASE_WR: begin
        mem_we    = 1'b1;
        mem_waddr = cell_addr(row_r, k_r);
        mem_wdata = CH_SPACE;
        k_nxt     = k_r + col_t'(1);
      end
      A_MISC: begin
        // single-step control codes; unknown bytes leave control pending
        case (code_r)
          CH_INS_ON: begin
            ins_nxt = 1'b1;
            ctl_nxt = 1'b0;
          end
          CH_INS_OFF: begin
            ins_nxt = 1'b0;
            ctl_nxt = 1'b0;
          end
          CH_HOME: begin
            row_nxt = '0;
            col_nxt = '0;
            ctl_nxt = 1'b0;
          end
          CH_BOL: begin
            col_nxt = '0;
            ctl_nxt = 1'b0;
          end
          CH_DOWN: begin
            if (row_r < ROW_LAST) begin
              row_nxt = row_r + row_t'(1);
            end
            ctl_nxt = 1'b0;
          end
          CH_UP: begin
            if (row_r > '0) begin
              row_nxt = row_r - row_t'(1);
            end
            ctl_nxt = 1'b0;
          end
          CH_LEFT: begin
            if (col_r > '0) begin
              col_nxt = col_r - col_t'(1);
            end
            ctl_nxt = 1'b0;
          end
          CH_RIGHT: begin
            if (col_r < COL_LAST) begin
              col_nxt = col_r + col_t'(1);
            end
            ctl_nxt = 1'b0;
          end
          default: begin
            if (code_r >= CH_DIG_LO && code_r <= CH_DIG_HI) begin
              if (!awc_r) begin
                // first digit picks the row, sequence stays open
                awc_nxt = 1'b1;
                row_nxt = (dig > 4'(ROWS - 1)) ? ROW_LAST : row_t'(dig);
              end else begin
                awc_nxt = 1'b0;
                col_nxt = (dig > 4'(COLS - 1)) ? COL_LAST : col_t'(dig);
                ctl_nxt = 1'b0;
              end
            end
          end
        endcase
      end
      A_EMIT: begin
        if (stat.out_free) begin
          out_nxt.cell_char       = cell_r;
          out_nxt.cursor_row      = 4'(row_r);
          out_nxt.cursor_col      = 4'(col_r);
          out_nxt.insert_on       = ins_r;
          out_nxt.control_pending = ctl_r;
          out_valid_nxt           = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // payload registers
  always_ff @(posedge clk) begin
    func_r <= func_nxt;
    code_r <= code_nxt;
    rrow_r <= rrow_nxt;
    rcol_r <= rcol_nxt;
    k_r    <= k_nxt;
    cell_r <= cell_nxt;
    out_r  <= out_nxt;
  end

  // control and cursor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      col_r       <= '0;
      ins_r       <= 1'b0;
      ctl_r       <= 1'b0;
      awc_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      ins_r       <= ins_nxt;
      ctl_r       <= ctl_nxt;
      awc_r       <= awc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[hdl/tti_screen.sv]
// screen cell memory with per-cell valid bits, unwritten cells read as space
module tti_screen (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               clr,
  input  logic               we,
  input  tti_pkg::addr_t     waddr,
  input  logic [7:0]         wdata,
  input  logic               re,
  input  tti_pkg::addr_t     raddr,
  output logic [7:0]         rdata
);
  import tti_pkg::*;

  logic [7:0]       mem_r [CELLS];
  logic [CELLS-1:0] valid_r;
  logic [7:0]       rdata_r;
  logic             rvld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rvld_r  <= 1'b0;
    end else begin
      if (clr) begin
        valid_r <= '0;
      end else if (we) begin
        valid_r[waddr] <= 1'b1;
      end
      if (re) begin
        rvld_r <= valid_r[raddr];
      end
    end
  end

  assign rdata = rvld_r ? rdata_r : CH_SPACE;

endmodule

[hdl/tti_seq.sv]
// microprogram sequencer: step counter, rom lookup and conditional jumps
module tti_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  tti_pkg::tti_stat_t  stat,
  output tti_pkg::ctrl_word_t cw
);
  import tti_pkg::*;

  upc_t upc_r;
  upc_t upc_nxt;
  logic taken;

  assign cw = microcode(upc_r);

  always_comb begin
    unique case (cw.cond)
      C_ALWAYS:     taken = 1'b1;
      C_FIRE:       taken = stat.fire;
      C_FUNC_RD:    taken = stat.func_rd;
      C_NEWLINE:    taken = stat.newline;
      C_PLAIN:      taken = !stat.in_ctl;
      C_CARET:      taken = stat.caret;
      C_CLEAR_CODE: taken = stat.clear_code;
      C_ERASE_CODE: taken = stat.erase_code;
      C_NO_INS:     taken = !stat.ins;
      C_SHIFT_DONE: taken = stat.shift_done;
      C_ERASE_LAST: taken = stat.erase_last;
      C_OUT_FREE:   taken = stat.out_free;
      default:      taken = 1'b1;
    endcase
    if (taken) begin
      upc_nxt = cw.target;
    end else if (cw.hold) begin
      upc_nxt = upc_r;
    end else begin
      upc_nxt = upc_r + UPC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= U_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule
